// ===== src/tqpr_pkg.sv =====
// Package with the shared types and constants of the two-queue page replacement block.
`timescale 1ns / 1ps
`default_nettype none
package tqpr_pkg;

   localparam int FRAMES_DEF      = 16;
   localparam int PIN_BITS_DEF    = 8;
   localparam int PAGE_W          = 64;
   localparam int FIDX_W          = 4;
   localparam int LIMIT_W         = 5;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   typedef enum logic {
      ACT_FIX   = 1'b0,
      ACT_UNFIX = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_FULL        = 2'd1,
      ST_NOT_RES     = 2'd2,
      ST_PIN_LIMIT   = 2'd3
   } status_type;

   typedef struct packed {
      action_type        action;
      logic [PAGE_W-1:0] page_id;
      logic              dirty_flag;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic              hit;
      logic [FIDX_W-1:0] frame_index;
      logic              read_needed;
      logic              evicted;
      logic [PAGE_W-1:0] evicted_page_id;
      logic              writeback;
   } rsp_type;

endpackage
`default_nettype wire

// ===== src/tqpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tqpr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== src/tqpr_front.sv =====
// Front end: accepts requests and holds them in a two-entry queue for the back end.
`timescale 1ns / 1ps
`default_nettype none
module tqpr_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire tqpr_pkg::req_type req_in,
   output logic                  busy,
   output logic                  q_valid,
   output tqpr_pkg::req_type     q_item,
   input  wire logic             q_pop
);
   import tqpr_pkg::*;

   req_type     buf_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push;
   logic        pop;

   assign busy    = (cnt_ff == 2'd2);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item  = buf_ff[rd_ptr_ff];
   assign push    = start && !busy;
   assign pop     = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         buf_ff[wr_ptr_ff] <= req_in;
      end
   end
endmodule
`default_nettype wire

// ===== src/tqpr_back.sv =====
// Back end: looks up the page, walks the FIFO and LRU queues and updates the frame state.
`timescale 1ns / 1ps
`default_nettype none
module tqpr_back #(
   parameter int FRAMES   = tqpr_pkg::FRAMES_DEF,
   parameter int PIN_BITS = tqpr_pkg::PIN_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [tqpr_pkg::LIMIT_W-1:0]   frame_limit,
   input  wire logic                           q_valid,
   input  wire tqpr_pkg::req_type              q_item,
   output logic                                q_pop,
   output logic                                rsp_strobe,
   output tqpr_pkg::rsp_type                   rsp
);
   import tqpr_pkg::*;

   localparam int FB = $clog2(FRAMES);
   localparam int CB = $clog2(FRAMES + 1);
   localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

   typedef enum logic [11:0] {
      S_IDLE   = 12'b0000_0000_0001,
      S_RD     = 12'b0000_0000_0010,
      S_CMP    = 12'b0000_0000_0100,
      S_DECIDE = 12'b0000_0000_1000,
      S_SCAN   = 12'b0000_0001_0000,
      S_REMOVE = 12'b0000_0010_0000,
      S_APPLRU = 12'b0000_0100_0000,
      S_EVRD   = 12'b0000_1000_0000,
      S_EVCAP  = 12'b0001_0000_0000,
      S_NEWPG  = 12'b0010_0000_0000,
      S_RESP   = 12'b0100_0000_0000,
      S_CLEAN  = 12'b1000_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   req_type            item_ff, item_in;
   logic [CB-1:0]      idx_ff, idx_in;
   logic [FB-1:0]      frm_ff, frm_in;
   logic [FB-1:0]      pos_ff, pos_in;
   logic               found_ff, found_in;
   logic               qsel_ff, qsel_in;
   logic               find_ff, find_in;
   logic [CB-1:0]      used_ff, used_in;
   logic [CB-1:0]      fifo_len_ff, fifo_len_in;
   logic [CB-1:0]      lru_len_ff, lru_len_in;
   logic [PIN_BITS-1:0] pins_ff [FRAMES];
   logic [PIN_BITS-1:0] pins_in [FRAMES];
   logic               dirty_ff [FRAMES];
   logic               dirty_in [FRAMES];
   logic               infifo_ff [FRAMES];
   logic               infifo_in [FRAMES];
   logic [FB-1:0]      fifo_ff [FRAMES];
   logic [FB-1:0]      fifo_in [FRAMES];
   logic [FB-1:0]      lru_ff [FRAMES];
   logic [FB-1:0]      lru_in [FRAMES];
   rsp_type            res_ff, res_in;

   logic [CB-1:0]      limit;
   logic [FB-1:0]      entry;
   logic [CB-1:0]      scan_len;
   logic [CB-1:0]      idx_next;
   logic [FB+FIDX_W-1:0] frm_ext;
   logic               ram_we;
   logic [FB-1:0]      ram_rd_addr;
   logic [PAGE_W-1:0]  ram_q;

   assign limit    = (32'(frame_limit) < FRAMES) ? CB'(frame_limit) : CB'(FRAMES);
   assign entry    = qsel_ff ? lru_ff[idx_ff[FB-1:0]] : fifo_ff[idx_ff[FB-1:0]];
   assign scan_len = qsel_ff ? lru_len_ff : fifo_len_ff;
   assign idx_next = idx_ff + CB'(1);
   assign frm_ext  = {{FIDX_W{1'b0}}, frm_ff};
   assign ram_we   = (state_ff == S_NEWPG);
   assign ram_rd_addr = (state_ff == S_EVRD) ? frm_ff : idx_ff[FB-1:0];
   assign q_pop    = (state_ff == S_IDLE) && q_valid;
   assign rsp_strobe = (state_ff == S_RESP);
   assign rsp      = res_ff;

   tqpr_ram #(.WIDTH(PAGE_W), .DEPTH(FRAMES)) u_page_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (frm_ff),
      .wr_data (item_ff.page_id),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      idx_in      = idx_ff;
      frm_in      = frm_ff;
      pos_in      = pos_ff;
      found_in    = found_ff;
      qsel_in     = qsel_ff;
      find_in     = find_ff;
      used_in     = used_ff;
      fifo_len_in = fifo_len_ff;
      lru_len_in  = lru_len_ff;
      pins_in     = pins_ff;
      dirty_in    = dirty_ff;
      infifo_in   = infifo_ff;
      fifo_in     = fifo_ff;
      lru_in      = lru_ff;
      res_in      = res_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               item_in  = q_item;
               idx_in   = '0;
               found_in = 1'b0;
               res_in   = '0;
               state_in = (used_ff == '0) ? S_DECIDE : S_RD;
            end
         end
         S_RD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (ram_q == item_ff.page_id) begin
               found_in = 1'b1;
               frm_in   = idx_ff[FB-1:0];
               state_in = S_DECIDE;
            end else if (idx_next == used_ff) begin
               state_in = S_DECIDE;
            end else begin
               idx_in   = idx_next;
               state_in = S_RD;
            end
         end
         S_DECIDE: begin
            idx_in = '0;
            if (item_ff.action == ACT_UNFIX) begin
               if (!found_ff) begin
                  res_in.status = ST_NOT_RES;
                  state_in = S_RESP;
               end else begin
                  dirty_in[frm_ff] = dirty_ff[frm_ff] | item_ff.dirty_flag;
                  if (pins_ff[frm_ff] != '0) begin
                     pins_in[frm_ff] = pins_ff[frm_ff] - PIN_BITS'(1);
                  end
                  res_in.frame_index = frm_ext[FIDX_W-1:0];
                  if (infifo_ff[frm_ff]) begin
                     state_in = S_RESP;
                  end else begin
                     qsel_in  = 1'b1;
                     find_in  = 1'b1;
                     state_in = S_SCAN;
                  end
               end
            end else if (found_ff) begin
               res_in.hit = 1'b1;
               res_in.frame_index = frm_ext[FIDX_W-1:0];
               if (pins_ff[frm_ff] >= PIN_MAX) begin
                  res_in.status = ST_PIN_LIMIT;
                  state_in = S_RESP;
               end else begin
                  pins_in[frm_ff] = pins_ff[frm_ff] + PIN_BITS'(1);
                  qsel_in  = !infifo_ff[frm_ff];
                  find_in  = 1'b1;
                  state_in = S_SCAN;
               end
            end else if (used_ff < limit) begin
               frm_in   = used_ff[FB-1:0];
               used_in  = used_ff + CB'(1);
               state_in = S_NEWPG;
            end else if (fifo_len_ff != '0) begin
               qsel_in  = 1'b0;
               find_in  = 1'b0;
               state_in = S_SCAN;
            end else if (lru_len_ff != '0) begin
               qsel_in  = 1'b1;
               find_in  = 1'b0;
               state_in = S_SCAN;
            end else begin
               res_in.status = ST_FULL;
               state_in = S_RESP;
            end
         end
         S_SCAN: begin
            if (find_ff ? (entry == frm_ff) : (pins_ff[entry] == '0)) begin
               pos_in   = idx_ff[FB-1:0];
               frm_in   = entry;
               state_in = S_REMOVE;
            end else if (idx_next >= scan_len) begin
               idx_in = '0;
               if (!qsel_ff && lru_len_ff != '0) begin
                  qsel_in = 1'b1;
               end else begin
                  res_in   = '0;
                  res_in.status = ST_FULL;
                  state_in = S_RESP;
               end
            end else begin
               idx_in = idx_next;
            end
         end
         S_REMOVE: begin
            for (int i = 0; i < FRAMES - 1; i++) begin
               if (FB'(i) >= pos_ff) begin
                  if (qsel_ff) begin
                     lru_in[i] = lru_ff[i + 1];
                  end else begin
                     fifo_in[i] = fifo_ff[i + 1];
                  end
               end
            end
            if (qsel_ff) begin
               lru_len_in = lru_len_ff - CB'(1);
            end else begin
               fifo_len_in = fifo_len_ff - CB'(1);
            end
            state_in = find_ff ? S_APPLRU : S_EVRD;
         end
         S_APPLRU: begin
            lru_in[lru_len_ff[FB-1:0]] = frm_ff;
            lru_len_in = lru_len_ff + CB'(1);
            infifo_in[frm_ff] = 1'b0;
            state_in = S_RESP;
         end
         S_EVRD: begin
            state_in = S_EVCAP;
         end
         S_EVCAP: begin
            res_in.evicted = 1'b1;
            res_in.evicted_page_id = ram_q;
            res_in.writeback = dirty_ff[frm_ff];
            state_in = S_NEWPG;
         end
         S_NEWPG: begin
            pins_in[frm_ff]   = PIN_BITS'(1);
            dirty_in[frm_ff]  = 1'b0;
            infifo_in[frm_ff] = 1'b1;
            fifo_in[fifo_len_ff[FB-1:0]] = frm_ff;
            fifo_len_in = fifo_len_ff + CB'(1);
            res_in.status = ST_OK;
            res_in.read_needed = 1'b1;
            res_in.frame_index = frm_ext[FIDX_W-1:0];
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         used_ff     <= '0;
         fifo_len_ff <= '0;
         lru_len_ff  <= '0;
         for (int i = 0; i < FRAMES; i++) begin
            pins_ff[i]   <= '0;
            dirty_ff[i]  <= 1'b0;
            infifo_ff[i] <= 1'b0;
         end
      end else begin
         state_ff    <= state_in;
         used_ff     <= used_in;
         fifo_len_ff <= fifo_len_in;
         lru_len_ff  <= lru_len_in;
         pins_ff     <= pins_in;
         dirty_ff    <= dirty_in;
         infifo_ff   <= infifo_in;
      end
      item_ff  <= item_in;
      idx_ff   <= idx_in;
      frm_ff   <= frm_in;
      pos_ff   <= pos_in;
      found_ff <= found_in;
      qsel_ff  <= qsel_in;
      find_ff  <= find_in;
      fifo_ff  <= fifo_in;
      lru_ff   <= lru_in;
      res_ff   <= res_in;
   end
endmodule
`default_nettype wire

// ===== src/two_queue_page_replacement.sv =====
// Top level of the two-queue page replacement block.
//
// A request is taken at a rising edge where start is high and busy is low.
// It carries an action (fix or unfix), a page id and a dirty flag.
// Requests wait in a two-entry queue; busy rises when that queue is full.
// Each request gives exactly one response, shown on the rsp_ ports for one
// cycle while rsp_strobe is high; the receiver cannot hold it off.
// The back end handles one request at a time. The lookup reads the page
// memory one frame at a time until the page is found or the frames in use
// are exhausted; where needed, a queue walk then visits one queue entry per
// cycle. A free frame is taken after the lookup; a moved hit walks its
// queue, removes the entry and puts it at the LRU tail; a replacement
// walks for an unpinned frame, removes it, reads the evicted page id and
// writes the new page. The response strobe ends every request. The user
// must write the frame limit through csr_wr_en and csr_wr_data only while
// the block is idle; the block itself does not enforce this. Reset empties
// both queues, frees all frames and sets the frame limit to sixteen.
`timescale 1ns / 1ps
`default_nettype none
module two_queue_page_replacement #(
   parameter int FRAMES   = tqpr_pkg::FRAMES_DEF,
   parameter int PIN_BITS = tqpr_pkg::PIN_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_action,
   input  wire logic [tqpr_pkg::PAGE_W-1:0]   req_page_id,
   input  wire logic                          req_dirty_flag,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_hit,
   output logic [tqpr_pkg::FIDX_W-1:0]        rsp_frame_index,
   output logic                               rsp_read_needed,
   output logic                               rsp_evicted,
   output logic [tqpr_pkg::PAGE_W-1:0]        rsp_evicted_page_id,
   output logic                               rsp_writeback,
   input  wire logic                          csr_wr_en,
   input  wire logic [tqpr_pkg::LIMIT_W-1:0]  csr_wr_data
);
   import tqpr_pkg::*;

   logic [LIMIT_W-1:0] limit_ff;
   req_type            req_in;
   req_type            q_item;
   logic               q_valid;
   logic               q_pop;
   rsp_type            rsp;

   always_comb begin
      req_in.action     = action_type'(req_action);
      req_in.page_id    = req_page_id;
      req_in.dirty_flag = req_dirty_flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   tqpr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_in  (req_in),
      .busy    (busy),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   tqpr_back #(.FRAMES(FRAMES), .PIN_BITS(PIN_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .frame_limit (limit_ff),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_strobe  (rsp_strobe),
      .rsp         (rsp)
   );

   assign rsp_status          = rsp.status;
   assign rsp_hit             = rsp.hit;
   assign rsp_frame_index     = rsp.frame_index;
   assign rsp_read_needed     = rsp.read_needed;
   assign rsp_evicted         = rsp.evicted;
   assign rsp_evicted_page_id = rsp.evicted_page_id;
   assign rsp_writeback       = rsp.writeback;
endmodule
`default_nettype wire
